/* hw/rtl/glb_pkg.sv */
// Shared types and constants for the greedy line breaker.
`timescale 1ns / 1ps

package glb_pkg;

    // Field widths of the character and line items.
    localparam int CODE_W    = 32;
    localparam int CWIDTH_W  = 10;
    localparam int START_W   = 16;
    localparam int INDEX_W   = 17;
    localparam int Y_W       = 26;
    localparam int RUN_W     = 27;
    localparam int MAXW_W    = 16;
    localparam int HEIGHT_W  = 10;

    // Configuration port widths and register indexes.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LINE_WIDTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_HEIGHT    = 4'd1;

    // Register reset values.
    localparam logic [MAXW_W-1:0]   MAX_LINE_WIDTH_RST = 16'hFFFF;
    localparam logic [HEIGHT_W-1:0] LINE_HEIGHT_RST    = 10'd32;

    // The newline code point closes a line.
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 32'h0000_000A;

    // Depth of the line record queue; two records may enter per cycle.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // One input character.
    typedef struct packed {
        logic [CODE_W-1:0]   code_point;
        logic [CWIDTH_W-1:0] char_width;
        logic                char_last;
    } char_t;

    // One line record.
    typedef struct packed {
        logic [START_W-1:0] line_start;
        logic [INDEX_W-1:0] line_end;
        logic [Y_W-1:0]     line_y;
        logic               result_last;
    } line_t;

    // Records produced by one character, in emission order.
    typedef struct packed {
        logic  first_valid;
        line_t first;
        logic  second_valid;
        line_t second;
    } line_push_t;

endpackage

/* hw/rtl/glb_line_state.sv */
// Running line state and record generation for the greedy line breaker.
`timescale 1ns / 1ps

module glb_line_state #(
    parameter int MAX_CHARS = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  glb_pkg::char_t                 item,
    input  logic [glb_pkg::MAXW_W-1:0]     max_line_width,
    input  logic [glb_pkg::HEIGHT_W-1:0]   line_height,
    output glb_pkg::line_push_t            push
);

    logic [glb_pkg::INDEX_W-1:0] char_index_reg, char_index_next;
    logic [glb_pkg::INDEX_W-1:0] start_index_reg, start_index_next;
    logic [glb_pkg::RUN_W-1:0]   run_width_reg, run_width_next;
    logic [glb_pkg::Y_W-1:0]     next_y_reg, next_y_next;

    logic                        active;
    logic                        is_nl;
    logic                        brk;
    logic                        flush;
    logic [glb_pkg::RUN_W:0]     run_sum;
    logic [glb_pkg::RUN_W-1:0]   run_sat;
    logic [glb_pkg::RUN_W-1:0]   run_after;
    logic [glb_pkg::Y_W:0]       y_sum;
    logic [glb_pkg::Y_W-1:0]     y_inc;
    logic [glb_pkg::Y_W-1:0]     y_flush;
    logic [glb_pkg::INDEX_W-1:0] idx_inc;
    logic [glb_pkg::INDEX_W-1:0] idx_after;
    logic [glb_pkg::INDEX_W-1:0] start_after;
    glb_pkg::line_t              rec_brk;
    glb_pkg::line_t              rec_flush;

    // Width accumulation and the break decision.
    always_comb
    begin
        active  = 32'(char_index_reg) < 32'(MAX_CHARS);
        is_nl   = item.code_point == glb_pkg::NEWLINE_CODE;
        run_sum = {1'b0, run_width_reg} + (glb_pkg::RUN_W + 1)'(item.char_width);
        run_sat = run_sum[glb_pkg::RUN_W] ? '1 : run_sum[glb_pkg::RUN_W-1:0];
        brk     = active && ((run_sat > glb_pkg::RUN_W'(max_line_width)) || is_nl);
        idx_inc = char_index_reg + glb_pkg::INDEX_W'(1);
        y_sum   = {1'b0, next_y_reg} + (glb_pkg::Y_W + 1)'(line_height);
        y_inc   = y_sum[glb_pkg::Y_W] ? '1 : y_sum[glb_pkg::Y_W-1:0];
    end

    // State after this character, before a paragraph end clears it.
    always_comb
    begin
        if (brk)
        begin
            start_after = is_nl ? idx_inc : char_index_reg;
            run_after   = is_nl ? '0 : glb_pkg::RUN_W'(item.char_width);
        end
        else
        begin
            start_after = start_index_reg;
            run_after   = active ? run_sat : run_width_reg;
        end
        idx_after = active ? idx_inc : char_index_reg;
        flush     = item.char_last && (start_after < idx_after);
        y_flush   = brk ? y_inc : next_y_reg;
    end

    // Line records for a break and for the paragraph flush.
    always_comb
    begin
        rec_brk.line_start    = start_index_reg[glb_pkg::START_W-1:0];
        rec_brk.line_end      = char_index_reg;
        rec_brk.line_y        = next_y_reg;
        rec_brk.result_last   = !flush;
        rec_flush.line_start  = start_after[glb_pkg::START_W-1:0];
        rec_flush.line_end    = idx_after;
        rec_flush.line_y      = y_flush;
        rec_flush.result_last = 1'b1;

        push.first_valid  = accept && (brk || flush);
        push.first        = brk ? rec_brk : rec_flush;
        push.second_valid = accept && brk && flush;
        push.second       = rec_flush;
    end

    // Next state; a paragraph end returns everything to zero.
    always_comb
    begin
        char_index_next  = char_index_reg;
        start_index_next = start_index_reg;
        run_width_next   = run_width_reg;
        next_y_next      = next_y_reg;
        if (accept)
        begin
            if (item.char_last)
            begin
                char_index_next  = '0;
                start_index_next = '0;
                run_width_next   = '0;
                next_y_next      = '0;
            end
            else
            begin
                char_index_next  = idx_after;
                start_index_next = start_after;
                run_width_next   = run_after;
                next_y_next      = brk ? y_inc : next_y_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_index_reg  <= '0;
            start_index_reg <= '0;
            run_width_reg   <= '0;
            next_y_reg      <= '0;
        end
        else
        begin
            char_index_reg  <= char_index_next;
            start_index_reg <= start_index_next;
            run_width_reg   <= run_width_next;
            next_y_reg      <= next_y_next;
        end
    end

    // A second record is only ever the flush after a break.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.second_valid |-> (push.first_valid && !push.first.result_last))
        else $error("second record without a leading break record");

    // A paragraph end leaves the state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.char_last) |=>
            (char_index_reg == '0 && start_index_reg == '0 && run_width_reg == '0
             && next_y_reg == '0))
        else $error("state not cleared after paragraph end");

    // The open line never starts past the next character index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !item.char_last && active && (char_index_reg != '1)) |=>
            (start_index_reg <= char_index_reg))
        else $error("line start beyond character index");

endmodule

/* hw/rtl/glb_out_queue.sv */
// Small queue of line records that takes up to two records per cycle.
`timescale 1ns / 1ps

module glb_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  glb_pkg::line_push_t push,
    output logic                room,
    output logic                line_valid,
    input  logic                line_stall,
    output glb_pkg::line_t      line_item
);

    glb_pkg::line_t                  entries [glb_pkg::QUEUE_DEPTH];
    logic [glb_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [glb_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [glb_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [glb_pkg::QUEUE_CNT_W-1:0] push_n;
    logic                            pop;

    // Handshake status depends on the fill level only.
    assign line_valid = count_reg != '0;
    assign room       = count_reg <= glb_pkg::QUEUE_CNT_W'(glb_pkg::QUEUE_DEPTH - 2);
    assign line_item  = entries[rd_ptr_reg];
    assign pop        = line_valid && !line_stall;

    // Pointer and fill level update.
    always_comb
    begin
        push_n      = glb_pkg::QUEUE_CNT_W'(push.first_valid)
                    + glb_pkg::QUEUE_CNT_W'(push.second_valid);
        wr_ptr_next = wr_ptr_reg + glb_pkg::QUEUE_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + glb_pkg::QUEUE_PTR_W'(pop);
        count_next  = count_reg + push_n - glb_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            entries[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            entries[wr_ptr_reg + glb_pkg::QUEUE_PTR_W'(1)] <= push.second;
        end
    end

    // Records arrive only when the queue has room for two.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.first_valid |-> room)
        else $error("record pushed into a full queue");

    // The fill level never exceeds the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= glb_pkg::QUEUE_CNT_W'(glb_pkg::QUEUE_DEPTH))
        else $error("queue fill level overflow");

endmodule

/* hw/rtl/greedy_line_breaker_core.sv */
// Top level of the greedy line breaker: configuration, line state and record queue.
//
// Characters enter on the char channel (char_valid, char_stall, char_item) and
// line records leave on the line channel (line_valid, line_stall, line_item).
// An item moves on a rising edge with valid high and stall low.
// A character is taken in every cycle with char_stall low; its break decision is
// one saturating add and compare on the running width, in the cycle it is accepted.
// Its records are registered into a four-entry queue whose head drives the line
// channel. A character yields zero, one or two records.
// Sustained rate is one character per cycle while line_stall is low and each
// yields at most one record; the queue accepts two records in a cycle and drains one.
// char_stall rises when fewer than two queue entries are free, which happens
// when the receiver holds line_stall or after a break and flush in one item.
// Registers are written through cfg_valid, cfg_ready, cfg_index and cfg_data;
// cfg_ready is always high. Index 0 is max_line_width, index 1 line_height.
// Reset clears the line state and the queue and restores the register
// defaults (65535 pixels, 32 pixels); there is no clearing pass.
`timescale 1ns / 1ps

module greedy_line_breaker_core #(
    parameter int MAX_CHARS = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              char_valid,
    output logic                              char_stall,
    input  glb_pkg::char_t                    char_item,
    output logic                              line_valid,
    input  logic                              line_stall,
    output glb_pkg::line_t                    line_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [glb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [glb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [glb_pkg::MAXW_W-1:0]   max_line_width_reg;
    logic [glb_pkg::HEIGHT_W-1:0] line_height_reg;
    logic                         room;
    logic                         accept;
    glb_pkg::line_push_t          push;

    assign cfg_ready  = 1'b1;
    assign char_stall = !room;
    assign accept     = char_valid && room;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_width_reg <= glb_pkg::MAX_LINE_WIDTH_RST;
            line_height_reg    <= glb_pkg::LINE_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                glb_pkg::REG_MAX_LINE_WIDTH:
                begin
                    max_line_width_reg <= cfg_data;
                end
                glb_pkg::REG_LINE_HEIGHT:
                begin
                    line_height_reg <= cfg_data[glb_pkg::HEIGHT_W-1:0];
                end
                default:
                begin
                    max_line_width_reg <= max_line_width_reg;
                end
            endcase
        end
    end

    // Running width, line start and y position.
    glb_line_state #(
        .MAX_CHARS(MAX_CHARS)
    ) u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .item           (char_item),
        .max_line_width (max_line_width_reg),
        .line_height    (line_height_reg),
        .push           (push)
    );

    // Line record queue toward the receiver.
    glb_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line_item  (line_item)
    );

endmodule
